// ----- src/qma_pkg.sv -----
package qma_pkg;

    localparam int MAX_NODES_DEF   = 16;
    localparam int TABLE_DEPTH_DEF = 16;
    localparam int TIME_BITS_DEF   = 48;
    localparam int NODE_W          = 5;
    localparam int OP_W            = 3;
    localparam int KIND_W          = 2;

    localparam logic [OP_W-1:0] OP_GRANT     = 3'd0;
    localparam logic [OP_W-1:0] OP_REQUEST   = 3'd1;
    localparam logic [OP_W-1:0] OP_INQUIRE   = 3'd2;
    localparam logic [OP_W-1:0] OP_YIELD     = 3'd3;
    localparam logic [OP_W-1:0] OP_RELEASE   = 3'd4;
    localparam logic [OP_W-1:0] OP_LOCAL_REQ = 3'd5;
    localparam logic [OP_W-1:0] OP_LOCAL_REL = 3'd6;

    localparam logic [KIND_W-1:0] KIND_GRANT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INQUIRE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_YIELD   = 2'd2;

    localparam logic [0:0] REG_OWN_ID     = 1'b0;
    localparam logic [0:0] REG_NODE_COUNT = 1'b1;

endpackage

// ----- src/qma_ram.sv -----
module qma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/qma_scan.sv -----
// scans the table memory one entry per cycle for the queue head
module qma_scan import qma_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [TABLE_DEPTH-1:0]         live,
    input  logic [NODE_W+TIME_BITS-1:0]    rdata,
    output logic [$clog2(TABLE_DEPTH)-1:0] raddr,
    output logic                           done,
    output logic                           found,
    output logic [$clog2(TABLE_DEPTH)-1:0] best_idx,
    output logic [NODE_W-1:0]              best_node,
    output logic [TIME_BITS-1:0]           best_time
);

    localparam int IW = $clog2(TABLE_DEPTH);

    logic [IW:0]   cnt_reg;
    logic          run_reg;
    logic          chk_reg;
    logic [IW-1:0] chk_idx_reg;
    logic          found_reg;
    logic [IW-1:0] best_idx_reg;
    logic [NODE_W-1:0]    best_node_reg;
    logic [TIME_BITS-1:0] best_time_reg;
    logic                 better;
    logic [NODE_W-1:0]    rd_node;
    logic [TIME_BITS-1:0] rd_time;

    assign rd_node = rdata[NODE_W+TIME_BITS-1:TIME_BITS];
    assign rd_time = rdata[TIME_BITS-1:0];
    assign raddr   = cnt_reg[IW-1:0];
    assign better  = !found_reg || rd_time < best_time_reg ||
                     (rd_time == best_time_reg && rd_node < best_node_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg   <= 1'b0;
            chk_reg   <= 1'b0;
            found_reg <= 1'b0;
            cnt_reg   <= '0;
            done      <= 1'b0;
        end else begin
            done    <= 1'b0;
            chk_reg <= run_reg;
            if (start) begin
                run_reg   <= 1'b1;
                cnt_reg   <= '0;
                found_reg <= 1'b0;
                chk_reg   <= 1'b0;
            end else if (run_reg) begin
                if (cnt_reg == (IW+1)'(TABLE_DEPTH - 1)) begin
                    run_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
            chk_idx_reg <= cnt_reg[IW-1:0];
            if (chk_reg && live[chk_idx_reg] && better) begin
                found_reg     <= 1'b1;
                best_idx_reg  <= chk_idx_reg;
                best_node_reg <= rd_node;
                best_time_reg <= rd_time;
            end
            if (chk_reg && !run_reg) begin
                done <= 1'b1;
            end
        end
    end

    assign found     = found_reg;
    assign best_idx  = best_idx_reg;
    assign best_node = best_node_reg;
    assign best_time = best_time_reg;

endmodule

// ----- src/quorum_mutex_arbiter_top.sv -----
// channel   | direction | ports
// request   | in        | s_valid s_ready s_operation s_sender s_request_time
// result    | out       | m_valid m_ready m_send_* m_in_critical m_table_full
// config    | in        | psel penable pwrite paddr pwdata prdata pready
// one request at a time; the result follows the serial scan of the table memory
// (one entry read per cycle), then the decide and finish states
// yield, release by the head, local release with own id in the quorum, and a request that
// displaces the own head outside the critical section merge and rescan with a second scan
// aresetn is synchronous; valid and delayed flags clear at once, no clearing pass
// s_ready is low from accept until the result is taken on the m_ side
module quorum_mutex_arbiter_top import qma_pkg::*; #(
    parameter int MAX_NODES   = MAX_NODES_DEF,
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [OP_W-1:0]      s_operation,
    input  logic [NODE_W-1:0]    s_sender,
    input  logic [TIME_BITS-1:0] s_request_time,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_send_valid,
    output logic [KIND_W-1:0]    m_send_kind,
    output logic [NODE_W-1:0]    m_send_dest,
    output logic                 m_in_critical,
    output logic                 m_table_full,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int EW = NODE_W + TIME_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_SCAN2, S_GRANT, S_FINISH, S_OUT
    } state_t;

    state_t state_reg;
    logic [NODE_W-1:0] own_id_reg, node_count_reg;
    logic [TABLE_DEPTH-1:0] valid_reg, delayed_reg;
    logic [MAX_NODES:0] marks_reg;
    logic crit_reg;
    logic [OP_W-1:0] op_reg;
    logic [NODE_W-1:0] snd_reg;
    logic [TIME_BITS-1:0] t_reg;
    logic sv_reg, full_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [NODE_W-1:0] dest_reg;

    logic we;
    logic [IW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;
    logic scan_start, scan_done, found;
    logic [IW-1:0] best_idx;
    logic [NODE_W-1:0] best_node;
    logic [TIME_BITS-1:0] best_time;
    logic [TABLE_DEPTH-1:0] live;

    logic [MAX_NODES:0] qmask;
    logic own_in_q, has_free, any_del, earlier, cfg_wr;
    logic rescan;
    logic [IW-1:0] free_idx;
    logic [NODE_W-1:0] put_node;
    logic [MAX_NODES:0] own_bit, snd_bit;

    assign live = valid_reg & ~delayed_reg;

    qma_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    qma_scan #(.TABLE_DEPTH(TABLE_DEPTH), .TIME_BITS(TIME_BITS)) u_scan (
        .aclk(aclk), .aresetn(aresetn), .start(scan_start), .live(live),
        .rdata(rdata), .raddr(raddr), .done(scan_done), .found(found),
        .best_idx(best_idx), .best_node(best_node), .best_time(best_time)
    );

    always_comb begin
        qmask = '0;
        for (int a = 1; a <= MAX_NODES; a = a * 2) begin
            if (a < int'(node_count_reg)) begin
                qmask[a] = 1'b1;
            end
        end
    end

    always_comb begin
        own_bit = '0;
        snd_bit = '0;
        for (int i = 1; i <= MAX_NODES; i++) begin
            if (own_id_reg == NODE_W'(i)) own_bit[i] = 1'b1;
            if (snd_reg == NODE_W'(i)) snd_bit[i] = 1'b1;
        end
    end

    assign own_in_q = |(own_bit & qmask);
    assign any_del  = |(valid_reg & delayed_reg);
    assign has_free = ~&valid_reg;
    always_comb begin
        free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!valid_reg[i]) free_idx = IW'(i);
        end
    end
    assign put_node = (op_reg == OP_LOCAL_REQ) ? own_id_reg : snd_reg;
    assign earlier  = t_reg < best_time ||
                      (t_reg == best_time && put_node < best_node);

    // operations that merge the queues and rescan for the new head (granted, or marked if own)
    assign rescan = (op_reg == OP_YIELD) ||
                    (op_reg == OP_RELEASE && found && best_node == snd_reg) ||
                    (op_reg == OP_LOCAL_REL && own_in_q) ||
                    (op_reg == OP_REQUEST && has_free && found && earlier &&
                     best_node == own_id_reg && !crit_reg);

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        case (paddr[2])
            REG_OWN_ID:     prdata[NODE_W-1:0] = own_id_reg;
            REG_NODE_COUNT: prdata[NODE_W-1:0] = node_count_reg;
            default:        prdata = '0;
        endcase
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = (state_reg == S_OUT);
    assign m_send_valid  = sv_reg;
    assign m_send_kind   = kind_reg;
    assign m_send_dest   = dest_reg;
    assign m_in_critical = crit_reg;
    assign m_table_full  = full_reg;
    assign wdata = {put_node, t_reg};
    assign waddr = free_idx;

    always_comb begin
        scan_start = 1'b0;
        we = 1'b0;
        if (state_reg == S_IDLE && s_valid) begin
            scan_start = 1'b1;
        end
        if (state_reg == S_DECIDE) begin
            if ((op_reg == OP_REQUEST || (op_reg == OP_LOCAL_REQ && own_in_q)) &&
                has_free) begin
                we = 1'b1;
            end
        end
        // the rescan needs its own start pulse
        if (state_reg == S_GRANT) begin
            scan_start = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            own_id_reg     <= NODE_W'(1);
            node_count_reg <= NODE_W'(16);
            valid_reg      <= '0;
            delayed_reg    <= '0;
            marks_reg      <= '0;
            crit_reg       <= 1'b0;
            sv_reg         <= 1'b0;
            full_reg       <= 1'b0;
            kind_reg       <= KIND_GRANT;
            dest_reg       <= '0;
        end else begin
            if (cfg_wr) begin
                case (paddr[2])
                    REG_OWN_ID:     own_id_reg <= pwdata[NODE_W-1:0];
                    REG_NODE_COUNT: node_count_reg <= pwdata[NODE_W-1:0];
                    default:        ;
                endcase
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg   <= s_operation;
                        snd_reg  <= s_sender;
                        t_reg    <= s_request_time;
                        sv_reg   <= 1'b0;
                        full_reg <= 1'b0;
                        kind_reg <= KIND_GRANT;
                        dest_reg <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_done) state_reg <= S_DECIDE;
                end
                S_DECIDE: begin
                    state_reg <= rescan ? S_GRANT : S_FINISH;
                    case (op_reg)
                        OP_GRANT: marks_reg <= marks_reg | snd_bit;
                        OP_REQUEST: begin
                            if (!has_free) begin
                                full_reg <= 1'b1;
                            end else if (!found) begin
                                valid_reg[free_idx]   <= 1'b1;
                                delayed_reg[free_idx] <= 1'b0;
                                sv_reg <= 1'b1; dest_reg <= snd_reg;
                            end else if (earlier) begin
                                valid_reg[free_idx] <= 1'b1;
                                if (best_node == own_id_reg && !crit_reg) begin
                                    // merged queue; rescan for the new head
                                    marks_reg   <= marks_reg & ~own_bit;
                                    delayed_reg <= '0;
                                end else if (best_node == own_id_reg) begin
                                    delayed_reg[free_idx] <= 1'b1;
                                end else begin
                                    if (!any_del) begin
                                        sv_reg <= 1'b1; kind_reg <= KIND_INQUIRE;
                                        dest_reg <= best_node;
                                    end
                                    delayed_reg[free_idx] <= 1'b1;
                                end
                            end else begin
                                valid_reg[free_idx]   <= 1'b1;
                                delayed_reg[free_idx] <= 1'b0;
                            end
                        end
                        OP_INQUIRE: begin
                            if (!crit_reg) begin
                                marks_reg <= marks_reg & ~snd_bit;
                                sv_reg <= 1'b1; kind_reg <= KIND_YIELD;
                                dest_reg <= snd_reg;
                            end
                        end
                        OP_YIELD: begin
                            delayed_reg <= '0;
                        end
                        OP_RELEASE: begin
                            if (found && best_node == snd_reg) begin
                                valid_reg[best_idx] <= 1'b0;
                                delayed_reg <= '0;
                            end
                        end
                        OP_LOCAL_REQ: begin
                            if (own_in_q && has_free && !found) begin
                                marks_reg <= {{MAX_NODES{1'b0}}, 1'b1} | own_bit;
                            end else begin
                                marks_reg <= {{MAX_NODES{1'b0}}, 1'b1};
                            end
                            if (own_in_q) begin
                                if (!has_free) begin
                                    full_reg <= 1'b1;
                                end else if (!found) begin
                                    valid_reg[free_idx]   <= 1'b1;
                                    delayed_reg[free_idx] <= 1'b0;
                                end else if (earlier) begin
                                    if (!any_del) begin
                                        sv_reg <= 1'b1; kind_reg <= KIND_INQUIRE;
                                        dest_reg <= best_node;
                                    end
                                    valid_reg[free_idx]   <= 1'b1;
                                    delayed_reg[free_idx] <= 1'b1;
                                end else begin
                                    valid_reg[free_idx]   <= 1'b1;
                                    delayed_reg[free_idx] <= 1'b0;
                                end
                            end
                        end
                        OP_LOCAL_REL: begin
                            crit_reg     <= 1'b0;
                            marks_reg[0] <= 1'b0;
                            if (own_in_q) begin
                                if (found) valid_reg[best_idx] <= 1'b0;
                                delayed_reg <= '0;
                            end
                        end
                        default: ;
                    endcase
                end
                S_GRANT: begin
                    state_reg <= S_SCAN2;
                end
                S_SCAN2: begin
                    if (scan_done) begin
                        state_reg <= S_FINISH;
                        if (found) begin
                            // a displaced own head grants the new head even if it is own
                            if (op_reg == OP_REQUEST || best_node != own_id_reg) begin
                                sv_reg <= 1'b1; kind_reg <= KIND_GRANT;
                                dest_reg <= best_node;
                            end else if (own_in_q) begin
                                marks_reg <= marks_reg | own_bit;
                            end
                        end
                    end
                end
                S_FINISH: begin
                    if (marks_reg[0] && ((marks_reg & qmask) == qmask)) begin
                        crit_reg <= 1'b1;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (m_ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready while result pending");
    a_full_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_table_full |-> !m_send_valid) else $error("send on full");
    a_crit_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(crit_reg) |-> marks_reg[0]) else $error("critical without pending");

endmodule
